// ===== design/mfipr_pkg.sv =====
package mfipr_pkg;

	localparam int WIN_SIZE = 16;
	localparam int WIN_AW   = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;
	localparam int RANK_W   = WIN_AW;
	localparam int LO_RANK  = WIN_SIZE / 2 - 1;
	localparam int HI_RANK  = WIN_SIZE / 2;

	localparam int SAMPLE_W = 12;
	localparam int SETPT_W  = 12;
	localparam int GAIN_W   = 8;
	localparam int DUTY_W   = 20;
	localparam int SLOPE_W  = 16;
	localparam int OFFS_W   = 8;
	localparam int PWM_W    = 11;
	localparam int MV_W     = 13;
	localparam int CFG_IW   = 3;

	localparam int PROD_W   = SLOPE_W + SAMPLE_W;
	localparam int CAL_SH   = 16;
	localparam int ERR_W    = MV_W + 1;
	localparam int TERM_W   = GAIN_W + 1 + ERR_W;
	localparam int SUM_W    = TERM_W + 1;

	localparam int DUTY_DIV = 1000;
	localparam int DIV_SH   = 30;
	localparam int DIV_MUL  = ((2 ** DIV_SH) + DUTY_DIV - 1) / DUTY_DIV;
	localparam int DIVM_W   = 21;
	localparam int DIVP_W   = DUTY_W + DIVM_W;

	localparam logic [DUTY_W-1:0] ACC_RESET = DUTY_W'(512000);
	localparam logic [PWM_W-1:0]  PWM_MAX   = PWM_W'(((2 ** DUTY_W) - 1) / DUTY_DIV);
	localparam logic [MV_W-1:0]   MV_MAX    =
		MV_W'(((((2 ** SLOPE_W) - 1) * ((2 ** SAMPLE_W) - 1) + 32768) >> CAL_SH)
		+ (2 ** OFFS_W) - 1);

	typedef enum logic [CFG_IW-1:0] {
		REG_SETPOINT = 3'd0,
		REG_GAIN     = 3'd1,
		REG_DUTY_MIN = 3'd2,
		REG_DUTY_MAX = 3'd3,
		REG_SLOPE    = 3'd4,
		REG_OFFSET   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [SETPT_W-1:0] setpoint_mv;
		logic [GAIN_W-1:0]  loop_gain;
		logic [DUTY_W-1:0]  duty_min;
		logic [DUTY_W-1:0]  duty_max;
		logic [SLOPE_W-1:0] cal_slope;
		logic [OFFS_W-1:0]  cal_offset;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RANK,
		ST_AVG,
		ST_MUL,
		ST_CAL,
		ST_ERR,
		ST_ACC,
		ST_DIV,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic sample_wr;
		logic rank_step;
		logic avg;
		logic mul;
		logic cal;
		logic err;
		logic acc;
		logic div;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic rank_last;
	} status_t;

endpackage

// ===== design/mfipr_cfg.sv =====
module mfipr_cfg import mfipr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [DUTY_W-1:0] cfg_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint_mv <= SETPT_W'(550);
			cfg_q.loop_gain   <= GAIN_W'(5);
			cfg_q.duty_min    <= DUTY_W'(51200);
			cfg_q.duty_max    <= DUTY_W'(921600);
			cfg_q.cal_slope   <= SLOPE_W'(17604);
			cfg_q.cal_offset  <= OFFS_W'(75);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_SETPOINT: cfg_q.setpoint_mv <= cfg_data[SETPT_W-1:0];
				REG_GAIN:     cfg_q.loop_gain   <= cfg_data[GAIN_W-1:0];
				REG_DUTY_MIN: cfg_q.duty_min    <= cfg_data;
				REG_DUTY_MAX: cfg_q.duty_max    <= cfg_data;
				REG_SLOPE:    cfg_q.cal_slope   <= cfg_data[SLOPE_W-1:0];
				REG_OFFSET:   cfg_q.cal_offset  <= cfg_data[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/mfipr_ctrl.sv =====
module mfipr_ctrl import mfipr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_next;
	logic   out_valid_q;
	logic   can_load;

	// The output register may be refilled in the same cycle its transaction completes.
	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_next = ST_RANK;
			ST_RANK: if (st.rank_last) state_next = ST_AVG;
			ST_AVG:  state_next = ST_MUL;
			ST_MUL:  state_next = ST_CAL;
			ST_CAL:  state_next = ST_ERR;
			ST_ERR:  state_next = ST_ACC;
			ST_ACC:  state_next = ST_DIV;
			ST_DIV:  state_next = ST_LOAD;
			ST_LOAD: if (can_load) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.sample_wr = in_valid;
			ST_RANK: cmd.rank_step = 1'b1;
			ST_AVG:  cmd.avg = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_CAL:  cmd.cal = 1'b1;
			ST_ERR:  cmd.err = 1'b1;
			ST_ACC:  cmd.acc = 1'b1;
			ST_DIV:  cmd.div = 1'b1;
			ST_LOAD: cmd.load = can_load;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/mfipr_dp.sv =====
module mfipr_dp import mfipr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             st,
	input  cfg_t                cfg,
	input  logic [SAMPLE_W-1:0] raw_sample,
	output logic [PWM_W-1:0]    pwm_duty,
	output logic [MV_W-1:0]     sensed_mv,
	output logic [SAMPLE_W-1:0] median_raw
);

	logic [SAMPLE_W-1:0]      win_q [WIN_SIZE];
	logic [WIN_AW-1:0]        wr_pos_q;
	logic [WIN_AW-1:0]        rank_idx_q;
	logic [SAMPLE_W-1:0]      lo_q, hi_q;
	logic [SAMPLE_W-1:0]      median_q;
	logic [PROD_W-1:0]        prod_q;
	logic [MV_W-1:0]          mv_q;
	logic signed [TERM_W-1:0] term_q;
	logic [DUTY_W-1:0]        acc_q;
	logic [DIVP_W-1:0]        divp_q;
	logic [PWM_W-1:0]         pwm_q;
	logic [MV_W-1:0]          mv_out_q;
	logic [SAMPLE_W-1:0]      med_out_q;

	logic [SAMPLE_W-1:0]      cand;
	logic [WIN_SIZE-1:0]      below;
	logic [RANK_W-1:0]        cand_rank;
	logic [SAMPLE_W:0]        mid_sum;
	logic [PROD_W:0]          prod_rnd;
	logic signed [ERR_W-1:0]  err;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  clamped;

	assign st.rank_last = (rank_idx_q == WIN_AW'(WIN_SIZE - 1));
	assign cand         = win_q[rank_idx_q];

	// Ties are broken by position, so every element gets a distinct rank.
	always_comb begin
		for (int j = 0; j < WIN_SIZE; j++) begin
			below[j] = (win_q[j] < cand) ||
				((win_q[j] == cand) && (WIN_AW'(j) < rank_idx_q));
		end
	end

	assign cand_rank = RANK_W'($countones(below));
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign prod_rnd  = {1'b0, prod_q} + (PROD_W+1)'(32768);
	assign err       = $signed({{(ERR_W-SETPT_W){1'b0}}, cfg.setpoint_mv})
		- $signed({1'b0, mv_q});

	always_comb begin
		sum = $signed({{(SUM_W-DUTY_W){1'b0}}, acc_q}) + SUM_W'(term_q);
		clamped = sum;
		if (clamped > $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_max})) begin
			clamped = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_max});
		end
		if (clamped < $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_min})) begin
			clamped = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_min});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_SIZE; i++) begin
				win_q[i] <= '0;
			end
			wr_pos_q <= '0;
			acc_q    <= ACC_RESET;
		end else begin
			if (cmd.sample_wr) begin
				win_q[wr_pos_q] <= raw_sample;
				if (wr_pos_q == WIN_AW'(WIN_SIZE - 1)) begin
					wr_pos_q <= '0;
				end else begin
					wr_pos_q <= wr_pos_q + WIN_AW'(1);
				end
			end
			if (cmd.acc) begin
				acc_q <= clamped[DUTY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample_wr) begin
			rank_idx_q <= '0;
		end else if (cmd.rank_step) begin
			if (cand_rank == RANK_W'(LO_RANK)) lo_q <= cand;
			if (cand_rank == RANK_W'(HI_RANK)) hi_q <= cand;
			rank_idx_q <= rank_idx_q + WIN_AW'(1);
		end
		if (cmd.avg) median_q <= mid_sum[SAMPLE_W:1];
		if (cmd.mul) prod_q <= PROD_W'(cfg.cal_slope) * PROD_W'(median_q);
		if (cmd.cal) begin
			mv_q <= MV_W'(prod_rnd[PROD_W:CAL_SH]) + MV_W'(cfg.cal_offset);
		end
		if (cmd.err) term_q <= TERM_W'($signed({1'b0, cfg.loop_gain})) * TERM_W'(err);
		// Division by the duty divisor as a multiplication by its rounded-up reciprocal,
		// exact for every accumulator value.
		if (cmd.div) divp_q <= DIVP_W'(acc_q) * DIVP_W'(DIV_MUL);
		if (cmd.load) begin
			pwm_q     <= divp_q[DIV_SH +: PWM_W];
			mv_out_q  <= mv_q;
			med_out_q <= median_q;
		end
	end

	assign pwm_duty   = pwm_q;
	assign sensed_mv  = mv_out_q;
	assign median_raw = med_out_q;

endmodule

// ===== design/median_filtered_integral_pwm_regulator.sv =====
// After the sample's transaction, the block ranks the window elements one at a time, then
// forms the median, calibrates it and updates the duty accumulator before the result is valid.
// Input stall is high from a sample's acceptance until its result is loaded.
// The output register holds a result until taken while the next sample is accepted.
// Reset (arst_n, asynchronous, active low) clears the window to zero, the write position,
// the duty accumulator to 512000 and the registers to their defaults.
module median_filtered_integral_pwm_regulator import mfipr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] raw_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [PWM_W-1:0]    pwm_duty,
	output logic [MV_W-1:0]     sensed_mv,
	output logic [SAMPLE_W-1:0] median_raw,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [DUTY_W-1:0]   cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	mfipr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mfipr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	mfipr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg        (cfg),
		.raw_sample (raw_sample),
		.pwm_duty   (pwm_duty),
		.sensed_mv  (sensed_mv),
		.median_raw (median_raw)
	);

	// Once a sample is taken, no further sample is accepted until its work is done.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sample accepted while another was in progress");

	a_pwm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pwm_duty <= PWM_MAX)
		else $error("duty quotient out of range");

	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sensed_mv <= MV_MAX)
		else $error("calibrated voltage out of range");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import mfipr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Indexes outside the register map: a write to either must change nothing.
	localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 40;
	localparam int CHUNKS        = 8;
	localparam int CHUNK_ITEMS   = 51;

	typedef struct {
		logic [PWM_W-1:0]    pwm;
		logic [MV_W-1:0]     mv;
		logic [SAMPLE_W-1:0] med;
	} reading_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [SAMPLE_W-1:0] raw_sample;
	logic                out_valid;
	logic                out_stall;
	logic [PWM_W-1:0]    pwm_duty;
	logic [MV_W-1:0]     sensed_mv;
	logic [SAMPLE_W-1:0] median_raw;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index;
	logic [DUTY_W-1:0]   cfg_data;

	// Predictor state: a private copy of the regulator.
	cfg_t                cfg_copy;
	logic [SAMPLE_W-1:0] window_copy [WIN_SIZE];
	int unsigned         slot_next;
	logic [DUTY_W-1:0]   duty_acc;

	reading_t readings_due[$];
	int       fault_count  = 0;
	int       src_idle_pct = 0;
	int       snk_idle_pct = 0;

	median_filtered_integral_pwm_regulator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_sample (raw_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pwm_duty   (pwm_duty),
		.sensed_mv  (sensed_mv),
		.median_raw (median_raw),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_regulation(input logic [SAMPLE_W-1:0] smp);
		logic [SAMPLE_W-1:0] ranked [WIN_SIZE];
		logic [SAMPLE_W-1:0] key;
		longint              med;
		longint              mv;
		longint              sum;
		int                  i;
		int                  j;
		reading_t            r;
		window_copy[slot_next] = smp;
		slot_next = (slot_next + 1) % WIN_SIZE;
		ranked = window_copy;
		for (i = 1; i < WIN_SIZE; i++) begin
			key = ranked[i];
			j = i - 1;
			while (j >= 0 && ranked[j] > key) begin
				ranked[j + 1] = ranked[j];
				j--;
			end
			ranked[j + 1] = key;
		end
		med = (longint'(ranked[HI_RANK]) + longint'(ranked[LO_RANK])) >> 1;
		mv  = ((longint'(cfg_copy.cal_slope) * med + 32768) >> CAL_SH)
			+ longint'(cfg_copy.cal_offset);
		// The sum is kept at full width so that a large error cannot wrap it.
		sum = longint'(duty_acc)
			+ longint'(cfg_copy.loop_gain) * (longint'(cfg_copy.setpoint_mv) - mv);
		if (sum > longint'(cfg_copy.duty_max))
			sum = longint'(cfg_copy.duty_max);
		if (sum < longint'(cfg_copy.duty_min))
			sum = longint'(cfg_copy.duty_min);
		duty_acc = DUTY_W'(sum);
		r.pwm = PWM_W'(duty_acc / DUTY_DIV);
		r.mv  = MV_W'(mv);
		r.med = SAMPLE_W'(med);
		readings_due.push_back(r);
	endfunction

	function automatic void apply_register(input logic [CFG_IW-1:0] idx,
			input logic [DUTY_W-1:0] data);
		case (cfg_idx_t'(idx))
			REG_SETPOINT: cfg_copy.setpoint_mv = data[SETPT_W-1:0];
			REG_GAIN:     cfg_copy.loop_gain   = data[GAIN_W-1:0];
			REG_DUTY_MIN: cfg_copy.duty_min    = data;
			REG_DUTY_MAX: cfg_copy.duty_max    = data;
			REG_SLOPE:    cfg_copy.cal_slope   = data[SLOPE_W-1:0];
			REG_OFFSET:   cfg_copy.cal_offset  = data[OFFS_W-1:0];
			default: ;
		endcase
	endfunction

	// Fills the bits above a register's width with noise; the block must drop them.
	function automatic logic [DUTY_W-1:0] with_junk(input int unsigned value, input int width);
		logic [DUTY_W-1:0] mask;
		mask = DUTY_W'((64'd1 << width) - 1);
		return (DUTY_W'($urandom) & ~mask) | (DUTY_W'(value) & mask);
	endfunction

	function automatic logic [SAMPLE_W-1:0] next_sample(input int level);
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 40)
			return SAMPLE_W'($urandom_range(4095));
		if (pick < 90) begin
			v = level + int'($urandom_range(128)) - 64;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return SAMPLE_W'(v);
		end
		return $urandom_range(1) ? {SAMPLE_W{1'b1}} : '0;
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		raw_sample <= smp;
		do @(posedge clk); while (in_stall);
		predict_regulation(smp);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DUTY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Holds the sender back until every outstanding result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (readings_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_random_config();
		int unsigned lo;
		int unsigned hi;
		int          mode;
		if ($urandom_range(7) == 0)
			write_reg(REG_SETPOINT, $urandom_range(1) ? 20'd4095 : 20'd0);
		else
			write_reg(REG_SETPOINT, DUTY_W'($urandom));
		mode = $urandom_range(9);
		if (mode < 5)
			write_reg(REG_GAIN, with_junk($urandom_range(15), GAIN_W));
		else if (mode < 9)
			write_reg(REG_GAIN, with_junk($urandom_range(255), GAIN_W));
		else
			write_reg(REG_GAIN, with_junk($urandom_range(1) ? 255 : 0, GAIN_W));
		mode = $urandom_range(9);
		if (mode < 7) begin
			lo = $urandom_range(400000);
			hi = $urandom_range(1048575, 500000);
		end else if (mode == 7) begin
			// Crossed limits: the lower limit, duty_min, wins.
			lo = $urandom_range(1048575, 500000);
			hi = $urandom_range(400000);
		end else if (mode == 8) begin
			lo = 0;
			hi = 1048575;
		end else begin
			lo = $urandom_range(1048575);
			hi = lo;
		end
		write_reg(REG_DUTY_MIN, DUTY_W'(lo));
		write_reg(REG_DUTY_MAX, DUTY_W'(hi));
		mode = $urandom_range(9);
		if (mode < 7)
			write_reg(REG_SLOPE, with_junk($urandom_range(21604, 13604), SLOPE_W));
		else if (mode < 9)
			write_reg(REG_SLOPE, with_junk($urandom_range(65535), SLOPE_W));
		else
			write_reg(REG_SLOPE, with_junk($urandom_range(1) ? 65535 : 0, SLOPE_W));
		write_reg(REG_OFFSET, with_junk($urandom_range(255), OFFS_W));
	endtask

	// The window starts full of zeros, so the median climbs only once half of it is filled.
	task automatic test_startup_window();
		int i;
		for (i = 0; i < 9; i++)
			send_sample({SAMPLE_W{1'b1}});
		send_sample('0);
		drain_results();
	endtask

	task automatic test_spare_index();
		write_reg(CFG_SPARE_LO, DUTY_W'($urandom));
		write_reg(CFG_SPARE_HI, {DUTY_W{1'b1}});
		send_sample(SAMPLE_W'(2048));
		send_sample(SAMPLE_W'(1365));
		drain_results();
	endtask

	task automatic test_register_extremes();
		int i;
		// Large positive step: full gain, top setpoint, low reading.
		write_reg(REG_SETPOINT, 20'd4095);
		write_reg(REG_GAIN, 20'd255);
		write_reg(REG_DUTY_MIN, 20'd0);
		write_reg(REG_DUTY_MAX, {DUTY_W{1'b1}});
		write_reg(REG_SLOPE, 20'd65535);
		write_reg(REG_OFFSET, 20'd255);
		for (i = 0; i < 3; i++)
			send_sample('0);
		drain_results();
		// Largest negative step: zero setpoint and a saturated reading.
		write_reg(REG_SETPOINT, 20'd0);
		for (i = 0; i < 3; i++)
			send_sample({SAMPLE_W{1'b1}});
		drain_results();
		write_reg(REG_DUTY_MIN, 20'd800000);
		write_reg(REG_DUTY_MAX, 20'd100000);
		send_sample(SAMPLE_W'(1000));
		send_sample(SAMPLE_W'(3000));
		drain_results();
		write_reg(REG_GAIN, 20'd0);
		write_reg(REG_SLOPE, 20'd0);
		write_reg(REG_OFFSET, 20'd0);
		send_sample(SAMPLE_W'(12'h555));
		send_sample(SAMPLE_W'(12'haaa));
		drain_results();
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct);
		int chunk;
		int i;
		int level;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			write_random_config();
			level = $urandom_range(4095);
			for (i = 0; i < CHUNK_ITEMS; i++)
				send_sample(next_sample(level));
			drain_results();
		end
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < snk_idle_pct);

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) begin
				$display("%0t: result with none expected: pwm_duty %0d sensed_mv %0d median_raw %0d",
					$time, pwm_duty, sensed_mv, median_raw);
				fault_count++;
			end else begin
				want = readings_due.pop_front();
				if (pwm_duty !== want.pwm) begin
					$display("%0t: pwm_duty expected %0d, got %0d", $time, want.pwm, pwm_duty);
					fault_count++;
				end
				if (sensed_mv !== want.mv) begin
					$display("%0t: sensed_mv expected %0d, got %0d", $time, want.mv, sensed_mv);
					fault_count++;
				end
				if (median_raw !== want.med) begin
					$display("%0t: median_raw expected %0d, got %0d", $time, want.med,
						median_raw);
					fault_count++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		raw_sample = '0;
		out_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		cfg_copy.setpoint_mv = SETPT_W'(550);
		cfg_copy.loop_gain   = GAIN_W'(5);
		cfg_copy.duty_min    = DUTY_W'(51200);
		cfg_copy.duty_max    = DUTY_W'(921600);
		cfg_copy.cal_slope   = SLOPE_W'(17604);
		cfg_copy.cal_offset  = OFFS_W'(75);
		foreach (window_copy[k])
			window_copy[k] = '0;
		slot_next = 0;
		duty_acc  = ACC_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 34;
		snk_idle_pct = 81;
		test_startup_window();
		test_spare_index();
		test_register_extremes();
		test_random_traffic(34, 81);
		test_random_traffic(81, 34);
		test_random_traffic(0, 0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
